>>> sv/sorted_table_binary_search_defines.svh
// Assertion macros used by the back end of the sorted table search RTL.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define STBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs assertion failed");
// Next-cycle implication, checked outside reset.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs assertion failed");
`else
`define STBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/stbs_pkg.sv
// Types and constants shared by the sorted table search block.
package stbs_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SPAN_W      = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths of the interface.
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 11;
    localparam int LOADIX_W  = 10;
    localparam int POS_W     = 10;

    // Request type codes.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Input word.
    typedef struct packed {
        logic                       req_type;
        logic [LOADIX_W-1:0]        load_index;
        logic signed [DATA_W-1:0]   load_value;
        logic signed [DATA_W-1:0]   search_key;
    } stbs_req_t;

    // Result word.
    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
    } stbs_rsp_t;

    // Classified word held in the queue between front and back.
    typedef struct packed {
        logic                       is_search;
        logic [IDX_W-1:0]           idx;
        logic signed [DATA_W-1:0]   data;
    } stbs_qword_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic           valid;
        stbs_qword_t    word;
    } stbs_link_t;

endpackage

>>> sv/sorted_table_binary_search.sv
// Top level of the sorted table search block: count register, front end and back end.
//
// A word with start high is taken whenever busy is low; busy rises only when
// the two-word queue between the front and back ends is full. A load word
// writes its table entry at the clock edge where it leaves the queue and gives
// no result; a load to a position outside the table is dropped. A search
// leaves the queue and then makes one table probe per cycle, at most
// log2(table depth) + 1 probes; the result is on the ports in the cycle
// after the last probe. The single registered read port of the table sets
// this one-probe-per-cycle pace. Each search result appears for exactly
// one cycle with done high and must be taken then, since the receiver cannot
// stall the block. The count register may be written only while no work is
// queued or running.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  stbs_req_t           req,
    output logic                done,
    output stbs_rsp_t           result,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0] used_count_reg, used_count_next;
    stbs_link_t         head;
    logic               pop;

    // Count register.
    assign used_count_next = cfg_we ? cfg_data : used_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else
        begin
            used_count_reg <= used_count_next;
        end
    end

    stbs_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    stbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_count (used_count_reg),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule

>>> sv/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/stbs_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module stbs_front
    import stbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  stbs_req_t   req,
    output stbs_link_t  head,
    input  logic        pop
);

    stbs_qword_t    slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    logic           accept;
    logic           keep;
    logic           push;
    stbs_qword_t    word;

    // A load outside the table is accepted and dropped here.
    assign busy   = (count_reg == 2'd2);
    assign accept = start && !busy;
    assign keep   = (req.req_type == REQ_SEARCH) ||
                    ({22'd0, req.load_index} < 32'(TABLE_DEPTH));
    assign push   = accept && keep;

    // Classify: a search carries its key, a load its value and address.
    always_comb
    begin
        word.is_search = (req.req_type == REQ_SEARCH);
        word.idx       = IDX_W'(req.load_index);
        word.data      = (req.req_type == REQ_SEARCH) ? req.search_key : req.load_value;
    end

    // Queue pointers and fill level.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= word;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.word  = slot_reg[rd_ptr_reg];

endmodule

>>> sv/stbs_back.sv
// Back end: performs table writes and runs the bisection search one probe per cycle.
`include "sorted_table_binary_search_defines.svh"
module stbs_back
    import stbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [COUNT_W-1:0]  used_count,
    input  stbs_link_t          head,
    output logic                pop,
    output logic                done,
    output stbs_rsp_t           result
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_PROBE = 1'b1;

    logic                       state_reg, state_next;
    logic [IDX_W-1:0]           low_reg, low_next;
    logic [IDX_W-1:0]           high_reg, high_next;
    logic [IDX_W-1:0]           mid_reg, mid_next;
    logic signed [DATA_W-1:0]   key_reg, key_next;
    logic                       done_reg, done_next;
    stbs_rsp_t                  rsp_reg, rsp_next;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_raddr;
    logic [DATA_W-1:0]          ram_rdata;
    logic signed [DATA_W-1:0]   elem;
    logic [SPAN_W-1:0]          span;
    logic [IDX_W-1:0]           high_init;
    logic                       key_lt;
    logic                       key_gt;
    logic [IDX_W-1:0]           lo_cand;
    logic [IDX_W-1:0]           hi_cand;
    logic [IDX_W:0]             bound_sum;

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head.word.idx),
        .wdata (head.word.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Count saturated to the table size; the first upper bound.
    assign span      = (32'(used_count) > 32'(TABLE_DEPTH)) ? SPAN_W'(TABLE_DEPTH)
                                                              : SPAN_W'(used_count);
    assign high_init = IDX_W'(span - SPAN_W'(1));

    // Compare the probed element and form the candidate bounds.
    assign elem    = ram_rdata;
    assign key_lt  = key_reg < elem;
    assign key_gt  = key_reg > elem;
    assign lo_cand = key_gt ? mid_reg + IDX_W'(1) : low_reg;
    assign hi_cand = key_lt ? mid_reg - IDX_W'(1) : high_reg;
    assign bound_sum = {1'b0, lo_cand} + {1'b0, hi_cand};

    // Sequencer: one queued word in idle, one probe per cycle afterwards.
    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        pop        = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = mid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (!head.word.is_search)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (span == SPAN_W'(0))
                    begin
                        // Empty table: no entry is read.
                        done_next         = 1'b1;
                        rsp_next.found    = 1'b0;
                        rsp_next.position = '0;
                    end
                    else
                    begin
                        key_next   = head.word.data;
                        low_next   = '0;
                        high_next  = high_init;
                        mid_next   = high_init >> 1;
                        ram_raddr  = high_init >> 1;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (!key_lt && !key_gt)
                begin
                    done_next         = 1'b1;
                    rsp_next.found    = 1'b1;
                    rsp_next.position = POS_W'(mid_reg);
                    state_next        = ST_IDLE;
                end
                else if ((key_lt && mid_reg == low_reg) || (key_gt && mid_reg == high_reg))
                begin
                    // Bounds have crossed.
                    done_next         = 1'b1;
                    rsp_next.found    = 1'b0;
                    rsp_next.position = '0;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    low_next  = lo_cand;
                    high_next = hi_cand;
                    mid_next  = IDX_W'(bound_sum >> 1);
                    ram_raddr = IDX_W'(bound_sum >> 1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Search payload registers.
    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        rsp_reg  <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // The probe always lies inside the current bounds.
    `STBS_ASSERT_IMPL(a_mid_in_bounds, clk, rst_n, state_reg == ST_PROBE,
        low_reg <= mid_reg && mid_reg <= high_reg)
    // Table writes happen only between searches.
    `STBS_ASSERT_IMPL(a_write_idle, clk, rst_n, ram_we, state_reg == ST_IDLE)
    // A miss always reports position zero.
    `STBS_ASSERT_IMPL(a_miss_zero, clk, rst_n, done_reg && !rsp_reg.found,
        rsp_reg.position == '0)
    // A finished probe returns the sequencer to idle with a result.
    `STBS_ASSERT_NEXT(a_probe_end, clk, rst_n,
        state_reg == ST_PROBE && state_next == ST_IDLE, done_reg)

endmodule

>>> bench/search_check_pkg.sv
// Scoreboard class that predicts and checks the results of the sorted table search block.
package search_check_pkg;
    import stbs_pkg::*;

    class lookup_scoreboard;
        // Own copy of the table and of the count register.
        logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
        logic [COUNT_W-1:0]       used_count;
        // Search results still owed by the block, oldest first.
        stbs_rsp_t                lookups_due [$];
        int                       failures;

        function new();
            used_count = '0;
            failures   = 0;
            foreach (entries[i])
            begin
                entries[i] = '0;
            end
        endfunction

        function void set_used_count(logic [COUNT_W-1:0] value);
            used_count = value;
        endfunction

        // Bisect the covered part of the table for one key.
        function stbs_rsp_t bisect(logic signed [DATA_W-1:0] key);
            int        span;
            int        low;
            int        high;
            int        mid;
            stbs_rsp_t rsp;
            // A count above the table depth covers the whole table.
            span = (int'(used_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(used_count);
            low  = 0;
            high = span - 1;
            rsp  = '0;
            while (low <= high)
            begin
                mid = (low + high) / 2;
                if (key < entries[mid])
                begin
                    high = mid - 1;
                end
                else if (key > entries[mid])
                begin
                    low = mid + 1;
                end
                else
                begin
                    rsp.found    = 1'b1;
                    rsp.position = POS_W'(mid);
                    break;
                end
            end
            return rsp;
        endfunction

        // Note one accepted word: a load updates the table, a search owes a result.
        function void note_word(stbs_req_t w);
            if (w.req_type == REQ_LOAD)
            begin
                if (int'(w.load_index) < TABLE_DEPTH)
                begin
                    entries[w.load_index] = w.load_value;
                end
            end
            else
            begin
                lookups_due.push_back(bisect(w.search_key));
            end
        endfunction

        // Compare one result word with the oldest owed result.
        function void check_result(stbs_rsp_t r);
            stbs_rsp_t want;
            if (lookups_due.size() == 0)
            begin
                $display("%0t: result word with no search pending: found=%0d position=%0d",
                         $time, r.found, r.position);
                failures++;
                return;
            end
            want = lookups_due.pop_front();
            if (r.found !== want.found || r.position !== want.position)
            begin
                $display("%0t: mismatch: expected found=%0d position=%0d, actual found=%0d position=%0d",
                         $time, want.found, want.position, r.found, r.position);
                failures++;
            end
        endfunction
    endclass

endpackage

>>> bench/tb_top.sv
// Testbench top for the sorted table search block: stimulus, result monitor and end check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stbs_pkg::*;
    import search_check_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 30;
    localparam int TOTAL_WORDS   = 620;
    localparam int CALM_TAIL     = 120;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    stbs_req_t          req;
    logic               done;
    stbs_rsp_t          result;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    lookup_scoreboard   sb;

    // Stimulus side view of the table, used to pick keys that hit.
    logic signed [DATA_W-1:0] shadow [TABLE_DEPTH];
    bit                       written [TABLE_DEPTH];
    // Positions on the two outer bisection paths of the whole table.
    int                       edges [$];
    int                       words_sent = 0;
    bit                       calm = 1'b0;
    bit                       tail = 1'b0;
    int unsigned              cycles = 0;

    sorted_table_binary_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Free-running clock.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watch both handshakes; results are checked before the word of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(result);
            end
            if (start && !busy)
            begin
                sb.note_word(req);
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] any_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Number of leading table entries that have been written.
    function automatic int written_prefix();
        int p = 0;
        while (p < TABLE_DEPTH && written[p])
        begin
            p++;
        end
        return p;
    endfunction

    // Present one word and hold it until the block takes it.
    task automatic send_word(stbs_req_t w);
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (w.req_type == REQ_LOAD)
        begin
            shadow[w.load_index]  = w.load_value;
            written[w.load_index] = 1'b1;
        end
        words_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random gap after a word, except in calm stretches and the tail of the run.
    task automatic maybe_pause();
        if (!calm && !tail && $urandom_range(0, 7) == 0)
        begin
            idle_cycles($urandom_range(1, 12));
        end
    endtask

    task automatic load_entry(int idx, logic signed [DATA_W-1:0] value);
        stbs_req_t w;
        w.req_type   = REQ_LOAD;
        w.load_index = LOADIX_W'(idx);
        w.load_value = value;
        w.search_key = $urandom;
        send_word(w);
        maybe_pause();
    endtask

    task automatic search_for(logic signed [DATA_W-1:0] key);
        stbs_req_t w;
        w.req_type   = REQ_SEARCH;
        w.load_index = LOADIX_W'($urandom);
        w.load_value = $urandom;
        w.search_key = key;
        send_word(w);
        maybe_pause();
    endtask

    // Stop sending until every owed result is in, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.lookups_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the count register while the block is idle.
    task automatic set_count(int value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= COUNT_W'(value);
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_used_count(COUNT_W'(value));
    endtask

    // Load positions 0..n-1, non-decreasing unless asked otherwise, in ascending or shuffled order.
    task automatic fill_table(int n, int max_step, bit unsorted);
        longint                   value;
        int                       order [$];
        int                       j;
        int                       tmp;
        logic signed [DATA_W-1:0] vals [$];
        value = longint'(any_value());
        for (int i = 0; i < n; i++)
        begin
            if (unsorted)
            begin
                vals.push_back(any_value());
            end
            else
            begin
                vals.push_back(value[31:0]);
                value += $urandom_range(0, max_step);
                if (value > 64'sd2147483647)
                begin
                    value = 64'sd2147483647;
                end
            end
            order.push_back(i);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            for (int i = n - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            load_entry(order[i], vals[order[i]]);
        end
    endtask

    // Ascending entries on the leftmost and rightmost bisection paths of the whole
    // table, so that searches for these values or for the extremes stay on them.
    task automatic load_edges();
        edges.delete();
        for (int k = 0; (1 << k) <= TABLE_DEPTH; k++)
        begin
            edges.push_back((1 << k) - 1);
        end
        for (int k = 0; (2 << k) < TABLE_DEPTH; k++)
        begin
            edges.push_back(TABLE_DEPTH - 1 - (1 << k));
        end
        foreach (edges[i])
        begin
            load_entry(edges[i], DATA_W'((edges[i] - TABLE_DEPTH / 2) * 1000));
        end
    endtask

    // Searches that only probe the entries written by load_edges.
    task automatic edge_searches(int k);
        int pick;
        search_for(32'sh8000_0000);
        search_for(32'sh7fff_ffff);
        for (int i = 0; i < k; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                search_for(32'sh8000_0000);
            end
            else if (pick == 1)
            begin
                search_for(32'sh7fff_ffff);
            end
            else
            begin
                search_for(shadow[edges[$urandom_range(0, edges.size() - 1)]]);
            end
        end
    endtask

    // Mostly keys taken from the covered entries, some near misses, some noise and stray loads.
    task automatic search_burst(int span, int k);
        int pick;
        int sign;
        for (int i = 0; i < k; i++)
        begin
            pick = $urandom_range(0, 9);
            sign = ($urandom_range(0, 1) == 1) ? 1 : -1;
            if (pick == 9)
            begin
                load_entry($urandom_range(0, TABLE_DEPTH - 1), any_value());
            end
            else if (span > 0 && pick < 5)
            begin
                search_for(shadow[$urandom_range(0, span - 1)]);
            end
            else if (span > 0 && pick < 7)
            begin
                search_for(shadow[$urandom_range(0, span - 1)] + sign);
            end
            else
            begin
                search_for(any_value());
            end
        end
    endtask

    task automatic random_round();
        int n;
        int span;
        int pick;
        int max_step;
        n    = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 100) : $urandom_range(1, 40);
        calm = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 2))
            0:       max_step = 3;
            1:       max_step = 1 << 12;
            default: max_step = 1 << 24;
        endcase
        fill_table(n, max_step, $urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            span = 0;
        end
        else if (pick == 1)
        begin
            span = $urandom_range(0, written_prefix());
        end
        else
        begin
            span = n;
        end
        set_count(span);
        search_burst(span, $urandom_range(4, 20));
    endtask

    initial
    begin
        sb = new();
        start    <= 1'b0;
        req      <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        rst_n    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table straight after reset.
        search_for(32'sd0);

        // Small sorted table with both extremes, loaded from the top down.
        load_entry(7, 32'sh7fff_ffff);
        load_entry(6, 32'sd1000);
        load_entry(5, 32'sd5);
        load_entry(4, 32'sd1);
        load_entry(3, 32'sd0);
        load_entry(2, -32'sd1);
        load_entry(1, -32'sd1000);
        load_entry(0, 32'sh8000_0000);
        set_count(8);
        search_for(32'sh8000_0000);
        search_for(32'sh7fff_ffff);
        search_for(32'sd0);
        search_for(32'sd5);
        search_for(-32'sd500);
        search_for(32'sd2000);

        // One-entry table.
        set_count(1);
        search_for(32'sh8000_0000);
        search_for(32'sh7fff_ffff);

        // Unsorted table: the bisection path decides the answer.
        load_entry(2, 32'sh7fff_ffff);
        set_count(8);
        search_for(32'sh7fff_ffff);
        search_for(-32'sd1);
        search_for(32'sd1000);
        load_entry(TABLE_DEPTH - 1, 32'sd0);

        // Random rounds for about half of the run.
        while (words_sent < TOTAL_WORDS / 2)
        begin
            random_round();
        end

        // Counts at and above the table depth, over the outer bisection paths.
        calm = 1'b0;
        load_edges();
        set_count((1 << COUNT_W) - 1);
        edge_searches(14);
        set_count(TABLE_DEPTH + 1);
        edge_searches(6);
        set_count(TABLE_DEPTH);
        edge_searches(10);

        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent > TOTAL_WORDS - CALM_TAIL)
            begin
                tail = 1'b1;
            end
            random_round();
        end

        // Wait for the last results, then report.
        drain();
        if (sb.failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/stbs_pkg.sv
sv/stbs_ram.sv
sv/stbs_front.sv
sv/stbs_back.sv
sv/sorted_table_binary_search.sv
bench/search_check_pkg.sv
bench/tb_top.sv
